FILE: hw/rtl/mpg_pkg.sv
// ----------------------------------------------------------------------------
// mpg_pkg
// Shared types, codes and constants for the birth-death Gillespie step block.
// ----------------------------------------------------------------------------
`default_nettype none

package mpg_pkg;

    // input command codes
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_STEP    = 1'b1;

    // configuration register indexes
    localparam logic CFG_POPULATION_SIZE = 1'b0;
    localparam logic CFG_FITNESS         = 1'b1;

    localparam logic [15:0] POP_RESET     = 16'd100;
    localparam logic [23:0] FIT_RESET     = 24'd65536;
    localparam logic [24:0] FIT_ONE       = 25'd65536;
    localparam logic [31:0] LN2_Q32       = 32'hB172_17F8;
    localparam logic [63:0] TAU_LIMIT_INT = 64'd1000000;

    typedef struct packed {
        logic        cmd;
        logic [31:0] u_time;
        logic [31:0] u_dir;
    } in_item_t;

    typedef struct packed {
        logic [15:0] count;
        logic [63:0] elapsed_time;
        logic        absorbed;
        logic        tau_clamped;
        logic        time_saturated;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_LOG,
        S_LNMUL,
        S_LNSUM,
        S_MUL,
        S_DIVCHK,
        S_DIV,
        S_TAU,
        S_FINISH
    } state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;
        logic norm;
        logic log_step;
        logic ln_mul;
        logic ln_sum;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic tau_sel;
        logic commit;
    } dp_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic step_active;
        logic ut_zero;
    } dp_stat_t;

    // log2 with 32 fraction bits by repeated squaring; used on constants only
    function automatic logic [36:0] log2_q32(input logic [31:0] x);
        logic [4:0]  e;
        logic [63:0] m;
        logic [31:0] frac;
        e    = '0;
        frac = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (x[i])
            begin
                e = 5'(i);
            end
        end
        m = 64'(x) << (5'd31 - e);
        for (int k = 0; k < 32; k++)
        begin
            m    = (m * m) >> 31;
            frac = {frac[30:0], 1'b0};
            if (m[32])
            begin
                frac[0] = 1'b1;
                m       = m >> 1;
            end
        end
        return {e, frac};
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mpg_ctrl.sv
// ----------------------------------------------------------------------------
// mpg_ctrl
// Sequencer: handshake, step counters and datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mpg_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    input  wire mpg_pkg::dp_stat_t stat,
    output mpg_pkg::dp_cmd_t       cmd
);

    mpg_pkg::state_t state_reg, state_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // state, counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpg_pkg::S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_ready = (state_reg == mpg_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            mpg_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mpg_pkg::S_SETUP;
                end
            end
            mpg_pkg::S_SETUP:
            begin
                if (!stat.step_active)
                begin
                    state_next = mpg_pkg::S_FINISH;
                end
                else if (stat.ut_zero)
                begin
                    state_next = mpg_pkg::S_TAU;
                end
                else
                begin
                    cmd.norm   = 1'b1;
                    cnt_next   = 6'd31;
                    state_next = mpg_pkg::S_LOG;
                end
            end
            mpg_pkg::S_LOG:
            begin
                cmd.log_step = 1'b1;
                cnt_next     = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    state_next = mpg_pkg::S_LNMUL;
                end
            end
            mpg_pkg::S_LNMUL:
            begin
                cmd.ln_mul = 1'b1;
                state_next = mpg_pkg::S_LNSUM;
            end
            mpg_pkg::S_LNSUM:
            begin
                cmd.ln_sum = 1'b1;
                cnt_next   = 6'd2;
                state_next = mpg_pkg::S_MUL;
            end
            mpg_pkg::S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    state_next = mpg_pkg::S_DIVCHK;
                end
            end
            mpg_pkg::S_DIVCHK:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = 6'd63;
                state_next   = mpg_pkg::S_DIV;
            end
            mpg_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    state_next = mpg_pkg::S_TAU;
                end
            end
            mpg_pkg::S_TAU:
            begin
                cmd.tau_sel = 1'b1;
                state_next  = mpg_pkg::S_FINISH;
            end
            mpg_pkg::S_FINISH:
            begin
                // result slot must be free before the state update
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = mpg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mpg_pkg::S_IDLE;
            end
        endcase
    end

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp_valid_reg || rsp_ready))
        else $error("commit while result slot occupied");

    a_one_iter_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.log_step, cmd.mul_step, cmd.div_step, cmd.load, cmd.commit}))
        else $error("conflicting datapath commands");

    a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == mpg_pkg::S_SETUP))
        else $error("accepted transaction did not start setup");

endmodule

`default_nettype wire

FILE: hw/rtl/mpg_dpath.sv
// ----------------------------------------------------------------------------
// mpg_dpath
// Datapath: config, count/time state, log unit, multiplier, divider, result.
// ----------------------------------------------------------------------------
`default_nettype none

module mpg_dpath
#(
    parameter int COUNT_WIDTH    = 16,
    parameter int RANDOM_WIDTH   = 32,
    parameter int TIME_FRAC_BITS = 24
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mpg_pkg::in_item_t req_data,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [23:0]       cfg_data,
    input  wire mpg_pkg::dp_cmd_t  cmd,
    output mpg_pkg::dp_stat_t      stat,
    output mpg_pkg::out_item_t     rsp_data
);

    localparam logic [31:0] RMASK   = 32'((64'd1 << RANDOM_WIDTH) - 64'd1);
    localparam logic [36:0] LOG2_M  = mpg_pkg::log2_q32(RMASK);
    localparam logic [63:0] LIMIT   = mpg_pkg::TAU_LIMIT_INT << TIME_FRAC_BITS;
    localparam int          Q_SHIFT = 32 - TIME_FRAC_BITS;

    // architectural state
    logic [15:0]            pop_reg;
    logic [23:0]            fit_reg;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [63:0]            time_reg, time_next;

    // per-transaction working registers
    logic        cmd_reg, active_reg, ut_zero_reg, up_reg;
    logic [31:0] ut_reg, ax_reg;
    logic [24:0] rp1_reg;
    logic [47:0] dp_reg;
    logic [56:0] den_reg;
    logic [31:0] m_reg, frac_reg;
    logic [4:0]  e_reg;
    logic [63:0] pl_reg;
    logic [36:0] ph_reg;
    logic [37:0] l32_reg;
    logic [79:0] prod_reg;
    logic [57:0] rem_reg;
    logic [63:0] numlo_reg, q_reg, tau_reg;
    logic        ovf_reg, clamp_reg;
    mpg_pkg::out_item_t out_reg;

    // load-time values
    logic [31:0] ut_in, ud_in;
    logic [15:0] x16, a16;
    logic        active_in;
    logic [24:0] rp1_in;
    logic [56:0] up_lhs, up_rhs;

    // iteration values
    logic [4:0]  e_find;
    logic [63:0] sq;
    logic [32:0] sq_sh;
    logic [36:0] lu, diff;
    logic [57:0] trial;
    logic [63:0] tau_raw;
    logic [64:0] tsum;
    logic        clamp_next;

    // load-time decode
    always_comb
    begin
        ut_in     = req_data.u_time & RMASK;
        ud_in     = req_data.u_dir & RMASK;
        x16       = 16'(count_reg);
        a16       = pop_reg - x16;
        active_in = (count_reg != '0) && (33'(count_reg) < 33'(pop_reg));
        rp1_in    = 25'(fit_reg) + mpg_pkg::FIT_ONE;
        up_lhs    = 57'(ud_in) * 57'(rp1_in);
        up_rhs    = (57'(fit_reg) << RANDOM_WIDTH) - 57'(fit_reg);
    end

    // leading one and squaring step
    always_comb
    begin
        e_find = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (ut_reg[i])
            begin
                e_find = 5'(i);
            end
        end
        sq    = 64'(m_reg) * 64'(m_reg);
        sq_sh = 33'(sq >> 31);
        lu    = {e_reg, frac_reg};
        diff  = (LOG2_M > lu) ? (LOG2_M - lu) : '0;
        trial = {rem_reg[56:0], numlo_reg[63]};
    end

    // waiting time select and state update
    always_comb
    begin
        tau_raw    = q_reg >> Q_SHIFT;
        clamp_next = ut_zero_reg || ovf_reg || (tau_raw > LIMIT);
        tsum       = 65'(time_reg) + 65'(tau_reg);
        count_next = count_reg;
        time_next  = time_reg;
        if (cmd_reg == mpg_pkg::CMD_RESTART)
        begin
            count_next = COUNT_WIDTH'(pop_reg >> 1);
            time_next  = '0;
        end
        else if (active_reg)
        begin
            time_next  = tsum[64] ? '1 : tsum[63:0];
            count_next = up_reg ? COUNT_WIDTH'(count_reg + 1'b1)
                                : COUNT_WIDTH'(count_reg - 1'b1);
        end
    end

    // configuration and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop_reg   <= mpg_pkg::POP_RESET;
            fit_reg   <= mpg_pkg::FIT_RESET;
            count_reg <= '0;
            time_reg  <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == mpg_pkg::CFG_POPULATION_SIZE))
            begin
                pop_reg <= cfg_data[15:0];
            end
            if (cfg_we && (cfg_index == mpg_pkg::CFG_FITNESS))
            begin
                fit_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
                time_reg  <= time_next;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg     <= req_data.cmd;
            active_reg  <= active_in;
            ut_zero_reg <= (ut_in == '0);
            up_reg      <= (up_lhs < up_rhs);
            ut_reg      <= ut_in;
            ax_reg      <= 32'(a16) * 32'(x16);
            rp1_reg     <= rp1_in;
            dp_reg      <= 48'(40'(fit_reg) * 40'(x16)) + {16'd0, a16, 16'd0};
        end
        if (cmd.norm)
        begin
            e_reg    <= e_find;
            m_reg    <= ut_reg << (5'd31 - e_find);
            frac_reg <= '0;
        end
        if (cmd.log_step)
        begin
            den_reg <= 57'(ax_reg) * 57'(rp1_reg);
            if (sq_sh[32])
            begin
                m_reg    <= sq_sh[32:1];
                frac_reg <= {frac_reg[30:0], 1'b1};
            end
            else
            begin
                m_reg    <= sq_sh[31:0];
                frac_reg <= {frac_reg[30:0], 1'b0};
            end
        end
        if (cmd.ln_mul)
        begin
            pl_reg <= 64'(diff[31:0]) * 64'(mpg_pkg::LN2_Q32);
            ph_reg <= 37'(diff[36:32]) * 37'(mpg_pkg::LN2_Q32);
        end
        if (cmd.ln_sum)
        begin
            l32_reg  <= 38'(ph_reg) + 38'(pl_reg[63:32]);
            prod_reg <= '0;
        end
        // one 16-bit digit of the rate numerator per step, top digit first
        if (cmd.mul_step)
        begin
            prod_reg <= {prod_reg[63:0], 16'd0} + 80'(54'(l32_reg) * 54'(dp_reg[47:32]));
            dp_reg   <= {dp_reg[31:0], 16'd0};
        end
        if (cmd.div_init)
        begin
            ovf_reg   <= (57'(prod_reg[79:64]) >= den_reg);
            rem_reg   <= 58'(prod_reg[79:64]);
            numlo_reg <= prod_reg[63:0];
            q_reg     <= '0;
        end
        // restoring division, one quotient bit per step
        if (cmd.div_step)
        begin
            numlo_reg <= {numlo_reg[62:0], 1'b0};
            if (trial >= 58'(den_reg))
            begin
                rem_reg <= trial - 58'(den_reg);
                q_reg   <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[62:0], 1'b0};
            end
        end
        if (cmd.tau_sel)
        begin
            tau_reg   <= clamp_next ? LIMIT : tau_raw;
            clamp_reg <= clamp_next;
        end
        if (cmd.commit)
        begin
            out_reg.count          <= 16'(count_next);
            out_reg.elapsed_time   <= time_next;
            out_reg.absorbed       <= (count_next == '0) ||
                                      (33'(count_next) >= 33'(pop_reg));
            out_reg.tau_clamped    <= (cmd_reg == mpg_pkg::CMD_STEP) && active_reg &&
                                      clamp_reg;
            out_reg.time_saturated <= (time_next == '1);
        end
    end

    assign stat.step_active = (cmd_reg == mpg_pkg::CMD_STEP) && active_reg;
    assign stat.ut_zero     = ut_zero_reg;
    assign rsp_data         = out_reg;

    a_restart_clears_time: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (cmd_reg == mpg_pkg::CMD_RESTART)) |=> (time_reg == '0))
        else $error("restart did not clear time");

    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (cmd_reg == mpg_pkg::CMD_STEP)) |=> (time_reg >= $past(time_reg)))
        else $error("elapsed time went backwards on a step");

    a_absorbed_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (cmd_reg == mpg_pkg::CMD_STEP) && !active_reg)
        |=> (count_reg == $past(count_reg)))
        else $error("count changed on a step while absorbed");

endmodule

`default_nettype wire

FILE: hw/rtl/moran_process_gillespie_step.sv
// Sequence: a restart or a step that changes nothing goes from acceptance through setup and finish to the result.
// A normal step: setup, 32 log squarings, 3 multiply digits, 64 divide bits, tau select, finish.
// A step with a zero time word skips the arithmetic and goes from setup to tau select and finish.
// Throughput: one transaction at a time; the log unit, divider and a still-held result set the rate.
// Reset (async, active low): count 0 (absorbed), time 0, N = 100, fitness = 1.0.
// ----------------------------------------------------------------------------
// moran_process_gillespie_step
// Birth-death process stepped by the Gillespie method, count and time kept.
// ----------------------------------------------------------------------------
`default_nettype none

module moran_process_gillespie_step
#(
    parameter int COUNT_WIDTH    = 16,
    parameter int RANDOM_WIDTH   = 32,
    parameter int TIME_FRAC_BITS = 24
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire mpg_pkg::in_item_t  req_data,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output mpg_pkg::out_item_t      rsp_data,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [23:0]        cfg_data
);

    mpg_pkg::dp_cmd_t  cmd;
    mpg_pkg::dp_stat_t stat;

    // sequencer
    mpg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // arithmetic and state
    mpg_dpath
    #(
        .COUNT_WIDTH    (COUNT_WIDTH),
        .RANDOM_WIDTH   (RANDOM_WIDTH),
        .TIME_FRAC_BITS (TIME_FRAC_BITS)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire
